[hw/rtl/rsps_pkg.sv]
package rsps_pkg;

   // Pixel FIFO
   localparam int FIFO_DEPTH = 2;
   localparam int FIFO_PTR_W = (FIFO_DEPTH > 1) ? $clog2(FIFO_DEPTH) : 1;
   localparam int FIFO_CNT_W = $clog2(FIFO_DEPTH + 1);

   // Field widths
   localparam int REG_W     = 11;
   localparam int PIXEL_W   = 32;
   localparam int ADDR_W    = 22;
   localparam int MISS_W    = 22;
   localparam int FRAME_W   = 32;
   localparam int VALID_LSB = 24;

   localparam logic [MISS_W-1:0] MISS_MAX = {MISS_W{1'b1}};

   // Configuration registers
   localparam int CSR_IDX_W = 3;
   localparam logic [CSR_IDX_W-1:0] CSR_ACTIVE_WIDTH  = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_TOTAL_WIDTH   = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_ACTIVE_HEIGHT = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_TOTAL_HEIGHT  = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_ROW_STRIDE    = 3'd4;

   localparam logic [REG_W-1:0] RST_ACTIVE_WIDTH  = 11'd640;
   localparam logic [REG_W-1:0] RST_TOTAL_WIDTH   = 11'd800;
   localparam logic [REG_W-1:0] RST_ACTIVE_HEIGHT = 11'd480;
   localparam logic [REG_W-1:0] RST_TOTAL_HEIGHT  = 11'd525;
   localparam logic [REG_W-1:0] RST_ROW_STRIDE    = 11'd640;

   // Input item kinds
   localparam logic MODE_TICK = 1'b0;
   localparam logic MODE_SEND = 1'b1;

   // Result payload, packed last field lowest
   typedef struct packed {
      logic [FRAME_W-1:0] frame_number;
      logic [MISS_W-1:0]  missed_count;
      logic [PIXEL_W-1:0] write_pixel;
      logic [ADDR_W-1:0]  write_address;
      logic               write_valid;
      logic               ready_res;
   } rsp_data_type;

   localparam int RSP_DATA_W  = $bits(rsp_data_type);
   localparam int RSP_TDATA_W = ((RSP_DATA_W + 7) / 8) * 8;

endpackage

[hw/rtl/raster_scan_pixel_sink.sv]
// Raster-timed pixel sink. Each request item is either a pixel clock tick
// (tuser 0) or a pixel offer (tuser 1, pixel word in tdata). An offer is
// pushed into a small FIFO when the ready flag left by the previous offer
// was set and bits 31:24 of the word are nonzero; the ready flag then
// becomes "FIFO below depth". A tick advances the column and line counters
// over the total frame; inside the active area it pops one pixel and emits
// a frame store write at line * row_stride + column, or counts a missed
// pixel (saturating). When the line counter reaches active_height the
// result carries tlast (frame end), the missed count before clearing and
// the bumped frame number. Every request yields exactly one response.
// Throughput is one item per clock unless rsp_tready stalls the output;
// an item passes the input register and then the response register, with
// the whole state update (an 11x11 multiply-add for the address and the
// counter compares) done in the logic between them. Write the csr_
// registers only while no item is in flight.
module raster_scan_pixel_sink (
   input  logic                                clock,
   input  logic                                reset,
   // request channel
   input  logic                                req_tvalid,
   output logic                                req_tready,
   input  logic [rsps_pkg::PIXEL_W-1:0]        req_tdata,  // pixel_value
   input  logic                                req_tuser,  // mode
   // response channel
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   // ready_res, write_valid, write_address, write_pixel, missed_count,
   // frame_number, zero pad
   output logic [rsps_pkg::RSP_TDATA_W-1:0]    rsp_tdata,
   output logic                                rsp_tlast,  // frame_end
   // configuration writes
   input  logic                                csr_we,
   input  logic [rsps_pkg::CSR_IDX_W-1:0]      csr_index,
   input  logic [rsps_pkg::REG_W-1:0]          csr_wdata
);
   import rsps_pkg::*;

   // Configuration
   logic [REG_W-1:0] active_width_ff, total_width_ff, active_height_ff;
   logic [REG_W-1:0] total_height_ff, row_stride_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         active_width_ff  <= RST_ACTIVE_WIDTH;
         total_width_ff   <= RST_TOTAL_WIDTH;
         active_height_ff <= RST_ACTIVE_HEIGHT;
         total_height_ff  <= RST_TOTAL_HEIGHT;
         row_stride_ff    <= RST_ROW_STRIDE;
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_ACTIVE_WIDTH:  active_width_ff  <= csr_wdata;
            CSR_TOTAL_WIDTH:   total_width_ff   <= csr_wdata;
            CSR_ACTIVE_HEIGHT: active_height_ff <= csr_wdata;
            CSR_TOTAL_HEIGHT:  total_height_ff  <= csr_wdata;
            CSR_ROW_STRIDE:    row_stride_ff    <= csr_wdata;
            default: ;  // unmapped index: drop the write
         endcase
      end
   end

   // Pipeline control: input register feeds the response register; the
   // input stage moves whenever the response slot is free or being drained.
   logic               in_valid_ff;
   logic               in_mode_ff;
   logic [PIXEL_W-1:0] in_pixel_ff;
   logic               rsp_valid_ff;
   logic               advance;

   assign advance    = in_valid_ff && (!rsp_valid_ff || rsp_tready);
   assign req_tready = !in_valid_ff || advance;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_tready) begin
         in_valid_ff <= req_tvalid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_tvalid && req_tready) begin
         in_mode_ff  <= req_tuser;
         in_pixel_ff <= req_tdata;
      end
   end

   // Sink state
   logic [PIXEL_W-1:0]    fifo_mem_ff [FIFO_DEPTH];
   logic [FIFO_PTR_W-1:0] head_ff;
   logic [FIFO_CNT_W-1:0] count_ff;
   logic                  ready_ff;
   logic [REG_W-1:0]      column_ff;
   logic [REG_W-1:0]      line_ff;
   logic [MISS_W-1:0]     missed_ff;
   logic [FRAME_W-1:0]    frame_ff;

   // Next-state logic
   logic                  is_send;
   logic                  push;
   logic                  pop;
   logic                  in_active;
   logic                  miss;
   logic [FIFO_PTR_W:0]   tail_sum;
   logic [FIFO_PTR_W-1:0] tail_idx;
   logic [FIFO_PTR_W-1:0] head_in;
   logic [FIFO_CNT_W-1:0] count_in;
   logic                  ready_in;
   logic [REG_W:0]        column_inc;
   logic [REG_W:0]        line_inc;
   logic                  col_wrap;
   logic                  frame_end;
   logic [REG_W-1:0]      column_in;
   logic [REG_W-1:0]      line_in;
   logic [MISS_W-1:0]     missed_run;
   logic [MISS_W-1:0]     missed_in;
   logic [FRAME_W-1:0]    frame_in;
   logic [2*REG_W:0]      addr_full;
   rsp_data_type          rsp_in;
   rsp_data_type          rsp_data_ff;
   logic                  rsp_last_ff;

   always_comb begin
      is_send   = (in_mode_ff == MODE_SEND);
      in_active = (column_ff < active_width_ff) && (line_ff < active_height_ff);

      // push only on a send that found the previous ready flag set
      push = is_send && ready_ff && (in_pixel_ff[PIXEL_W-1:VALID_LSB] != '0)
             && (count_ff < FIFO_CNT_W'(FIFO_DEPTH));
      pop  = !is_send && in_active && (count_ff != '0);
      miss = !is_send && in_active && (count_ff == '0);

      tail_sum = {1'b0, head_ff} + (FIFO_PTR_W + 1)'(count_ff);
      if (tail_sum >= (FIFO_PTR_W + 1)'(FIFO_DEPTH)) begin
         tail_sum = tail_sum - (FIFO_PTR_W + 1)'(FIFO_DEPTH);
      end
      tail_idx = tail_sum[FIFO_PTR_W-1:0];

      head_in = head_ff;
      if (pop) begin
         head_in = (head_ff == FIFO_PTR_W'(FIFO_DEPTH - 1)) ? '0 : head_ff + 1'b1;
      end
      count_in = count_ff;
      if (push) begin
         count_in = count_ff + 1'b1;
      end else if (pop) begin
         count_in = count_ff - 1'b1;
      end

      // ready is recomputed on sends only; ticks hold it
      ready_in = is_send ? (count_in < FIFO_CNT_W'(FIFO_DEPTH)) : ready_ff;

      // raster counters
      column_inc = {1'b0, column_ff} + 1'b1;
      line_inc   = {1'b0, line_ff} + 1'b1;
      col_wrap   = column_inc >= {1'b0, total_width_ff};
      frame_end  = !is_send && col_wrap && (line_inc == {1'b0, active_height_ff});

      column_in = column_ff;
      line_in   = line_ff;
      if (!is_send) begin
         column_in = col_wrap ? '0 : column_inc[REG_W-1:0];
         if (col_wrap) begin
            line_in = (line_inc >= {1'b0, total_height_ff}) ? '0 : line_inc[REG_W-1:0];
         end
      end

      // saturating miss counter; report the count before a frame-end clear
      missed_run = missed_ff;
      if (miss && (missed_ff != MISS_MAX)) begin
         missed_run = missed_ff + 1'b1;
      end
      missed_in = frame_end ? '0 : missed_run;
      frame_in  = frame_end ? frame_ff + 1'b1 : frame_ff;

      addr_full = (2*REG_W + 1)'(line_ff) * (2*REG_W + 1)'(row_stride_ff)
                  + (2*REG_W + 1)'(column_ff);

      rsp_in.ready_res     = ready_in;
      rsp_in.write_valid   = pop;
      rsp_in.write_address = pop ? addr_full[ADDR_W-1:0] : '0;
      rsp_in.write_pixel   = pop ? fifo_mem_ff[head_ff] : '0;
      rsp_in.missed_count  = missed_run;
      rsp_in.frame_number  = frame_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff   <= '0;
         count_ff  <= '0;
         ready_ff  <= 1'b0;
         column_ff <= '0;
         line_ff   <= '0;
         missed_ff <= '0;
         frame_ff  <= '0;
      end else if (advance) begin
         head_ff   <= head_in;
         count_ff  <= count_in;
         ready_ff  <= ready_in;
         column_ff <= column_in;
         line_ff   <= line_in;
         missed_ff <= missed_in;
         frame_ff  <= frame_in;
      end
   end

   // FIFO storage: no reset, only written entries are ever popped
   always_ff @(posedge clock) begin
      if (advance && push) begin
         fifo_mem_ff[tail_idx] <= in_pixel_ff;
      end
   end

   // Response register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         rsp_data_ff <= rsp_in;
         rsp_last_ff <= frame_end;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = RSP_TDATA_W'(rsp_data_ff);
   assign rsp_tlast  = rsp_last_ff;

endmodule

[tb/raster_shadow_pkg.sv]
`timescale 1ns / 1ps

package raster_shadow_pkg;

   import rsps_pkg::*;

   class raster_shadow;

      typedef struct {
         rsp_data_type payload;
         logic         frame_end;
      } response_type;

      // raster geometry as last written
      int unsigned act_w, tot_w, act_h, tot_h, stride;

      // block state
      logic [PIXEL_W-1:0] pixel_q[$];
      bit                 ready_flag;
      int unsigned        column, line;
      logic [MISS_W-1:0]  missed;
      logic [FRAME_W-1:0] frames;

      response_type pending_responses[$];

      int errors, n_items, n_checked, n_dropped, n_writes, n_frames;

      function new();
         act_w  = 32'(RST_ACTIVE_WIDTH);
         tot_w  = 32'(RST_TOTAL_WIDTH);
         act_h  = 32'(RST_ACTIVE_HEIGHT);
         tot_h  = 32'(RST_TOTAL_HEIGHT);
         stride = 32'(RST_ROW_STRIDE);
         ready_flag = 0;
         column = 0;
         line = 0;
         missed = '0;
         frames = '0;
      endfunction

      function void write_reg(logic [CSR_IDX_W-1:0] idx, logic [REG_W-1:0] value);
         case (idx)
            CSR_ACTIVE_WIDTH:  act_w  = 32'(value);
            CSR_TOTAL_WIDTH:   tot_w  = 32'(value);
            CSR_ACTIVE_HEIGHT: act_h  = 32'(value);
            CSR_TOTAL_HEIGHT:  tot_h  = 32'(value);
            CSR_ROW_STRIDE:    stride = 32'(value);
            default: ;
         endcase
      endfunction

      function int pending();
         return pending_responses.size();
      endfunction

      // Advance the shadow state by one accepted item and queue its response.
      function void accept_item(logic mode, logic [PIXEL_W-1:0] pixel);
         response_type r;
         logic [31:0]  addr;
         r.payload = '0;
         r.frame_end = 1'b0;
         n_items++;
         if (mode == MODE_SEND) begin
            // ready from the previous offer gates the push; full FIFO drops
            if (ready_flag && pixel[PIXEL_W-1:VALID_LSB] != '0 &&
                pixel_q.size() < FIFO_DEPTH) begin
               pixel_q.push_back(pixel);
            end else begin
               n_dropped++;
            end
            ready_flag = pixel_q.size() < FIFO_DEPTH;
            r.payload.missed_count = missed;
         end else begin
            if (column < act_w && line < act_h) begin
               if (pixel_q.size() > 0) begin
                  addr = line * stride + column;
                  r.payload.write_pixel   = pixel_q.pop_front();
                  r.payload.write_valid   = 1'b1;
                  r.payload.write_address = addr[ADDR_W-1:0];
                  n_writes++;
               end else if (missed != MISS_MAX) begin
                  missed++;
               end
            end
            r.payload.missed_count = missed;
            // wrap on "at or above" so shrunken totals recover at once
            column++;
            if (column >= tot_w) begin
               column = 0;
               line++;
               if (line == act_h) begin
                  r.frame_end = 1'b1;
                  missed = '0;
                  frames++;
                  n_frames++;
               end
               if (line >= tot_h) line = 0;
            end
         end
         r.payload.ready_res = ready_flag;
         r.payload.frame_number = frames;
         pending_responses.push_back(r);
      endfunction

      function void compare_field(string name, logic [63:0] want, logic [63:0] got);
         if (want !== got) begin
            errors++;
            $display("%0t: %s mismatch: expected 0x%0h, actual 0x%0h",
                     $time, name, want, got);
         end
      endfunction

      function void check_response(logic [RSP_TDATA_W-1:0] tdata, logic tlast);
         response_type want;
         rsp_data_type got;
         if (pending_responses.size() == 0) begin
            errors++;
            $display("%0t: response with none expected: actual tdata 0x%0h tlast %0b",
                     $time, tdata, tlast);
            return;
         end
         want = pending_responses.pop_front();
         got = rsp_data_type'(tdata[RSP_DATA_W-1:0]);
         n_checked++;
         compare_field("ready_res", 64'(want.payload.ready_res), 64'(got.ready_res));
         compare_field("write_valid", 64'(want.payload.write_valid),
                       64'(got.write_valid));
         compare_field("write_address", 64'(want.payload.write_address),
                       64'(got.write_address));
         compare_field("write_pixel", 64'(want.payload.write_pixel),
                       64'(got.write_pixel));
         compare_field("frame_end", 64'(want.frame_end), 64'(tlast));
         compare_field("missed_count", 64'(want.payload.missed_count),
                       64'(got.missed_count));
         compare_field("frame_number", 64'(want.payload.frame_number),
                       64'(got.frame_number));
      endfunction

   endclass

endpackage

[tb/tb_raster_scan_pixel_sink.sv]
`timescale 1ns / 1ps

module tb_raster_scan_pixel_sink;

   import rsps_pkg::*;
   import raster_shadow_pkg::*;

   localparam int LIMIT_CYCLES = 200000;
   localparam int HOLD_CYCLES  = 80;

   logic                   clock = 1'b0;
   logic                   reset;
   logic                   req_tvalid;
   logic                   req_tready;
   logic [PIXEL_W-1:0]     req_tdata;   // pixel_value
   logic                   req_tuser;   // mode
   logic                   rsp_tvalid;
   logic                   rsp_tready;
   // ready_res, write_valid, write_address, write_pixel, missed_count,
   // frame_number, zero pad
   logic [RSP_TDATA_W-1:0] rsp_tdata;
   logic                   rsp_tlast;   // frame_end
   logic                   csr_we;
   logic [CSR_IDX_W-1:0]   csr_index;
   logic [REG_W-1:0]       csr_wdata;

   raster_shadow shadow;
   bit           hold_request;
   int           cycle_count;

   raster_scan_pixel_sink i_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   always #1 clock = ~clock;

   // Watchdog: end the run if the block wedges or starves.
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count == LIMIT_CYCLES) begin
         $display("%0t: timeout after %0d cycles, %0d responses outstanding",
                  $time, cycle_count, shadow.pending());
         $display("CHECK FAILED");
         $finish;
      end
   end

   // Sample both handshakes on the rising edge. Note the input item first,
   // so a response can never be checked ahead of the item that caused it.
   always @(posedge clock) begin
      if (!reset) begin
         if (req_tvalid && req_tready) shadow.accept_item(req_tuser, req_tdata);
         if (rsp_tvalid && rsp_tready) shadow.check_response(rsp_tdata, rsp_tlast);
      end
   end

   // Output side: switch between stall styles after random stretches, and
   // on request hold off completely for a long stretch so the block backs up.
   initial begin
      int style, left, k;
      rsp_tready = 1'b0;
      style = 0;
      left = 0;
      forever begin
         @(negedge clock);
         if (hold_request) begin
            hold_request = 0;
            rsp_tready = 1'b0;
            for (k = 0; k < HOLD_CYCLES; k++) @(negedge clock);
         end
         if (left == 0) begin
            style = $urandom_range(0, 3);
            left = $urandom_range(30, 120);
         end
         left--;
         case (style)
            0: rsp_tready = 1'b1;
            1: rsp_tready = 1'($urandom_range(0, 1));
            2: rsp_tready = ($urandom_range(0, 7) != 0);
            default: rsp_tready = (left % 3 == 0);
         endcase
      end
   end

   // Present one item from a falling edge and hold it until accepted.
   // Leave tvalid high afterwards; the caller drops it for a gap.
   task automatic offer(logic mode, logic [PIXEL_W-1:0] pixel);
      req_tvalid = 1'b1;
      req_tuser = mode;
      req_tdata = pixel;
      do @(posedge clock); while (!req_tready);
      @(negedge clock);
   endtask

   // Mostly valid pixels; drop the top byte now and then so the offer is
   // ignored by the FIFO.
   function automatic logic [PIXEL_W-1:0] random_pixel();
      logic [PIXEL_W-1:0] v;
      v = $urandom;
      if ($urandom_range(0, 7) == 0) v[PIXEL_W-1:VALID_LSB] = '0;
      return v;
   endfunction

   task automatic csr_write(logic [CSR_IDX_W-1:0] idx, logic [REG_W-1:0] value);
      csr_we = 1'b1;
      csr_index = idx;
      csr_wdata = value;
      @(posedge clock);
      shadow.write_reg(idx, value);
      @(negedge clock);
   endtask

   task automatic apply_geometry(int aw, int tw, int ah, int th, int rs);
      csr_write(CSR_ACTIVE_WIDTH, REG_W'(aw));
      csr_write(CSR_TOTAL_WIDTH, REG_W'(tw));
      csr_write(CSR_ACTIVE_HEIGHT, REG_W'(ah));
      csr_write(CSR_TOTAL_HEIGHT, REG_W'(th));
      csr_write(CSR_ROW_STRIDE, REG_W'(rs));
      csr_we = 1'b0;
   endtask

   // Drop valid, then wait until every response is back before touching
   // the registers; add a short pause for the pipeline to settle.
   task automatic wait_drained();
      req_tvalid = 1'b0;
      while (shadow.pending() != 0) @(posedge clock);
      repeat (4) @(negedge clock);
   endtask

   // Bursts of random length with a random mix of offers and ticks; the mix
   // swings per burst so the FIFO both runs dry and fills up.
   task automatic run_items(int count);
      int left, blen, i, send_pct, gap;
      left = count;
      while (left > 0) begin
         blen = $urandom_range(1, 16);
         send_pct = $urandom_range(20, 80);
         for (i = 0; i < blen && left > 0; i++) begin
            if ($urandom_range(0, 99) < send_pct) offer(MODE_SEND, random_pixel());
            else offer(MODE_TICK, $urandom);
            left--;
         end
         if ($urandom_range(0, 3) != 0) begin
            gap = $urandom_range(1, 5);
            req_tvalid = 1'b0;
            repeat (gap) @(negedge clock);
         end
      end
   endtask

   initial begin
      int p, k;
      shadow = new();
      hold_request = 0;
      reset = 1'b1;
      req_tvalid = 1'b0;
      req_tuser = MODE_TICK;
      req_tdata = '0;
      csr_we = 1'b0;
      csr_index = CSR_ACTIVE_WIDTH;
      csr_wdata = '0;
      repeat (9) @(negedge clock);
      reset = 1'b0;

      // Reset geometry. Ready starts low, so the first offer is dropped.
      offer(MODE_SEND, 32'hFF12_3456);
      // tick in the active area with an empty FIFO: missed pixel
      offer(MODE_TICK, '0);
      // zero top byte: ignored even though ready is set
      offer(MODE_SEND, 32'h00AB_CDEF);
      offer(MODE_SEND, 32'h0100_0000);
      offer(MODE_SEND, 32'hFFFF_FFFF);
      // FIFO full: ready low, this one is dropped
      offer(MODE_SEND, 32'h8000_0001);
      offer(MODE_TICK, 32'hFFFF_FFFF);
      offer(MODE_TICK, '0);
      // ready was low from the full FIFO, so drop this and raise ready
      offer(MODE_SEND, 32'h7FFF_FFFF);
      wait_drained();

      // Tiny frame with the widest stride; the column is already at the
      // new total, so the first tick wraps straight away. Run past a frame end.
      apply_geometry(2, 3, 2, 3, 2047);
      repeat (5) begin
         offer(MODE_SEND, random_pixel() | 32'h0100_0000);
         offer(MODE_TICK, '0);
         offer(MODE_TICK, '0);
      end
      wait_drained();

      for (p = 0; p < 8; p++) begin
         case (p)
            // no active area, column wraps every tick, line always back to 0
            1: apply_geometry(0, 0, 0, 0, 0);
            // one pixel per line, tallest frame, line walks up fast
            3: apply_geometry(2047, 1, 2047, 2047, 2047);
            // widest line
            4: apply_geometry(2047, 2047, 1, 2, $urandom_range(0, 2047));
            // active area larger than the total
            6: apply_geometry($urandom_range(4, 9), $urandom_range(1, 3),
                              $urandom_range(3, 6), $urandom_range(1, 2),
                              $urandom_range(0, 2047));
            default: apply_geometry($urandom_range(0, 6), $urandom_range(1, 8),
                                    $urandom_range(1, 5), $urandom_range(1, 7),
                                    $urandom_range(0, 2047));
         endcase
         // long output stall while the sender keeps pushing
         if (p == 2) hold_request = 1;
         run_items(p == 3 ? 300 : 140);
         wait_drained();
      end

      for (k = 0; k < 10; k++) @(posedge clock);
      if (shadow.pending() != 0) begin
         shadow.errors++;
         $display("%0t: %0d expected responses never arrived", $time, shadow.pending());
      end

      $display("Ran %0d items (%0d offers dropped): %0d responses checked,",
               shadow.n_items, shadow.n_dropped, shadow.n_checked);
      $display("%0d writes, %0d frame ends; geometries: reset, tiny, all-zero,",
               shadow.n_writes, shadow.n_frames);
      $display("2047 extremes, active beyond total; one %0d-cycle output stall",
               HOLD_CYCLES);
      if (shadow.errors == 0) begin
         $display("CHECK OK");
      end else begin
         $display("CHECK FAILED");
      end
      $finish;
   end

endmodule

[filelist.f]
hw/rtl/rsps_pkg.sv
hw/rtl/raster_scan_pixel_sink.sv
tb/raster_shadow_pkg.sv
tb/tb_raster_scan_pixel_sink.sv
